@@ design/lpvi_pkg.sv @@
package lpvi_pkg;

	localparam int QF = 24;
	localparam int QM = 30;
	localparam logic [23:0] PMAX = 24'hFF_FFFF;

	typedef logic [31:0] root_tab_t [0:QF];

	// Integer square root, one result bit per pass.
	function automatic logic [63:0] isqrt64(input logic [63:0] a);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] one_v;
		rem = a;
		res = '0;
		one_v = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + one_v) begin
				rem = rem - (res + one_v);
				res = (res >> 1) + one_v;
			end else begin
				res = res >> 1;
			end
			one_v = one_v >> 2;
		end
		return res;
	endfunction

	// Entry j holds 2^(2^-j) in unsigned Q2.30, each one the square root of the one before.
	function automatic root_tab_t gen_roots();
		root_tab_t t;
		t[0] = 32'h8000_0000;
		for (int j = 1; j <= QF; j++) begin
			t[j] = 32'(isqrt64({32'd0, t[j-1]} << QM));
		end
		return t;
	endfunction

	localparam root_tab_t ROOT_TAB = gen_roots();

	typedef struct packed {
		logic               done;
		logic signed [31:0] value;
	} log_res_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_res_t;

	typedef struct packed {
		logic        done;
		logic [23:0] pressure;
	} exp_res_t;

endpackage

@@ design/lpvi_log.sv @@
module lpvi_log (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [23:0]        value,
	output lpvi_pkg::log_res_t res
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [4:0]  e_q;
	logic [30:0] x_q;
	logic [23:0] frac_q;

	logic [23:0] v;
	logic [4:0]  e;
	logic [30:0] x0;
	logic [61:0] sq;
	logic [31:0] xs;

	always_comb begin
		v = (value == 24'd0) ? 24'd1 : value;
		e = '0;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) e = 5'(i);
		end
		x0 = 31'({7'd0, v} << (5'd30 - e));
		sq = 62'(x_q) * 62'(x_q);
		xs = sq[61:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(lpvi_pkg::QF - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One squaring per cycle yields one fraction bit of the logarithm.
	always_ff @(posedge clk) begin
		if (start) begin
			e_q    <= e;
			x_q    <= x0;
			frac_q <= '0;
		end else if (busy_q) begin
			if (xs[31]) begin
				x_q <= xs[31:1];
				frac_q[5'd23 - cnt_q] <= 1'b1;
			end else begin
				x_q <= xs[30:0];
			end
		end
	end

	assign res.done  = done_q;
	assign res.value = $signed({3'd0, e_q, frac_q}) - 32'sh0800_0000;

endmodule

@@ design/lpvi_div.sv @@
module lpvi_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        dividend,
	input  logic [32:0]        divisor,
	output lpvi_pkg::div_res_t res
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] den_q;

	logic [33:0] trial;
	logic        fits;

	always_comb begin
		trial = {rem_q, quo_q[63]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division: the dividend shifts out as quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, den_q}) : trial[32:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

@@ design/lpvi_exp.sv @@
module lpvi_exp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] log_in,
	output lpvi_pkg::exp_res_t res
);

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

	state_t      state_q;
	logic        done_q;
	logic [23:0] p_q;
	logic [4:0]  j_q;
	logic [5:0]  ni_q;
	logic [23:0] f_q;
	logic [31:0] mant_q;

	logic signed [63:0] y;
	logic signed [63:0] yy;
	logic               sat_hi;
	logic               sat_lo;
	logic [63:0]        prod;
	logic [6:0]         s;
	logic [63:0]        rnd;

	always_comb begin
		y      = log_in + 64'sh0800_0000;
		sat_hi = y >= 64'sh1800_0000;
		sat_lo = y < -64'sh2800_0000;
		yy     = y + 64'sh2800_0000;
		prod   = 64'(mant_q) * 64'(lpvi_pkg::ROOT_TAB[j_q]);
		s      = 7'd70 - 7'(ni_q);
		rnd    = (64'(mant_q) + (64'd1 << (s - 7'd1))) >> s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			j_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (sat_hi || sat_lo) begin
							done_q <= 1'b1;
							p_q    <= sat_hi ? lpvi_pkg::PMAX : 24'd0;
						end else begin
							state_q <= S_RUN;
							j_q     <= 5'd1;
							ni_q    <= yy[29:24];
							f_q     <= yy[23:0];
							mant_q  <= 32'h4000_0000;
						end
					end
				end
				// One root of two per cycle, applied where the fraction bit is set.
				S_RUN: begin
					if (f_q[5'(lpvi_pkg::QF) - j_q]) mant_q <= prod[61:30];
					j_q <= j_q + 5'd1;
					if (j_q == 5'(lpvi_pkg::QF)) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (ni_q <= 6'd30) p_q <= 24'd0;
					else if (rnd > 64'(lpvi_pkg::PMAX)) p_q <= lpvi_pkg::PMAX;
					else p_q <= rnd[23:0];
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.done     = done_q;
	assign res.pressure = p_q;

endmodule

@@ design/log_pressure_vertical_interp.sv @@
// Pressure items run 24 squarings in the log unit; height items are written to the level memory directly.
// A last height item then emits one result per target height, each set by a search of the levels,
// the 64-step divider and the 24-step exp unit.
// busy is high until the last result has been strobed; results cannot be stalled.
// arst_n clears control state and loads the register defaults; the level memories are
// undefined until written.
module log_pressure_vertical_interp #(
	parameter int MAX_LEVELS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [4:0]         level_index,
	input  logic [23:0]        pressure_value,
	input  logic signed [31:0] height_value,
	input  logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               result_valid,
	output logic [4:0]         height_level,
	output logic [23:0]        pressure_out,
	output logic               div_error,
	output logic               last_out
);

	localparam int AW = $clog2(MAX_LEVELS);

	localparam logic [1:0] REG_NUM_PLEVELS = 2'd0;
	localparam logic [1:0] REG_NUM_ZLEVELS = 2'd1;
	localparam logic [1:0] REG_BASE_HEIGHT = 2'd2;
	localparam logic [1:0] REG_HEIGHT_STEP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_LOG, S_TGT, S_RDZ, S_CHKZ, S_RDL0, S_RDL1, S_CAPL,
		S_DIVS, S_DIV, S_EXP, S_NEXT
	} state_t;

	logic signed [31:0] zmem [MAX_LEVELS];
	logic signed [31:0] lmem [MAX_LEVELS];

	state_t             state_q;
	logic [4:0]         np_q;
	logic [4:0]         nz_q;
	logic signed [31:0] base_q;
	logic [30:0]        step_q;

	logic [AW-1:0]      widx_q;
	logic               wok_q;
	logic signed [37:0] acc_q;
	logic signed [31:0] zt_q;
	logic [4:0]         k_q;
	logic [AW-1:0]      i_q;
	logic [AW-1:0]      r_q;
	logic               below_q;
	logic signed [31:0] zprev_q;
	logic signed [31:0] zr_q;
	logic signed [31:0] zrm_q;
	logic signed [31:0] lprm_q;
	logic signed [31:0] lpr_q;
	logic signed [63:0] num_q;
	logic signed [32:0] dz_q;
	logic               neg_q;
	logic signed [31:0] z_rd_q;
	logic signed [31:0] l_rd_q;

	logic               result_valid_q;
	logic [4:0]         height_level_q;
	logic [23:0]        pressure_out_q;
	logic               div_error_q;
	logic               last_out_q;

	logic               accept;
	logic               idx_ok;
	logic [AW-1:0]      in_addr;
	logic               z_rd_en;
	logic [AW-1:0]      z_rd_addr;
	logic               l_rd_en;
	logic [AW-1:0]      l_rd_addr;
	logic [AW-1:0]      np_last;
	logic [4:0]         nz_eff;
	logic signed [31:0] zt_sat;
	logic signed [32:0] zd;
	logic signed [32:0] ld;
	logic signed [32:0] dz;
	logic signed [65:0] prod;
	logic [63:0]        num_mag;
	logic [32:0]        dz_mag;
	logic [63:0]        q_signed;
	logic signed [63:0] lr;
	logic               log_start;
	logic               div_start;
	logic               exp_start;

	lpvi_pkg::log_res_t log_res;
	lpvi_pkg::div_res_t div_res;
	lpvi_pkg::exp_res_t exp_res;

	assign accept    = start && !busy;
	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign idx_ok    = 32'(level_index) < MAX_LEVELS;
	assign in_addr   = AW'(level_index);

	always_comb begin
		int npc;
		npc = int'(np_q);
		if (npc < 2) npc = 2;
		if (npc > MAX_LEVELS) npc = MAX_LEVELS;
		np_last = AW'(npc - 1);
		nz_eff = (32'(nz_q) > MAX_LEVELS) ? 5'(MAX_LEVELS) : nz_q;

		if (acc_q > 38'sh00_7FFF_FFFF) zt_sat = 32'sh7FFF_FFFF;
		else if (acc_q < -38'sh00_8000_0000) zt_sat = -32'sh8000_0000;
		else zt_sat = acc_q[31:0];

		z_rd_en   = state_q == S_RDZ;
		z_rd_addr = i_q;
		l_rd_en   = (state_q == S_RDL0) || (state_q == S_RDL1);
		l_rd_addr = (state_q == S_RDL0) ? r_q - AW'(1) : r_q;

		zd   = 33'(zr_q) - 33'(zt_q);
		ld   = 33'(l_rd_q) - 33'(lprm_q);
		dz   = 33'(zr_q) - 33'(zrm_q);
		prod = 66'(zd) * 66'(ld);

		num_mag  = num_q[63] ? 64'(-num_q) : 64'(num_q);
		dz_mag   = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);
		q_signed = neg_q ? -div_res.quotient : div_res.quotient;
		lr       = 64'(lpr_q) - $signed(q_signed);

		log_start = accept && !kind;
		div_start = state_q == S_DIVS;
		exp_start = (state_q == S_DIV) && div_res.done;
	end

	always_ff @(posedge clk) begin
		if (accept && kind && idx_ok) zmem[in_addr] <= height_value;
		if (state_q == S_LOG && log_res.done && wok_q) lmem[widx_q] <= log_res.value;
		if (z_rd_en) z_rd_q <= zmem[z_rd_addr];
		if (l_rd_en) l_rd_q <= lmem[l_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			np_q <= 5'd2;
			nz_q <= 5'd1;
			base_q <= '0;
			step_q <= 31'd256;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_NUM_PLEVELS: np_q   <= cfg_data[4:0];
				REG_NUM_ZLEVELS: nz_q   <= cfg_data[4:0];
				REG_BASE_HEIGHT: base_q <= $signed(cfg_data);
				REG_HEIGHT_STEP: step_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			k_q            <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						widx_q <= in_addr;
						wok_q  <= idx_ok;
						if (!kind) begin
							state_q <= S_LOG;
						end else if (last && nz_eff != 5'd0) begin
							state_q <= S_TGT;
							k_q     <= '0;
							acc_q   <= 38'(base_q);
						end
					end
				end
				S_LOG: begin
					if (log_res.done) state_q <= S_IDLE;
				end
				S_TGT: begin
					zt_q    <= zt_sat;
					i_q     <= '0;
					state_q <= S_RDZ;
				end
				S_RDZ: state_q <= S_CHKZ;
				// Level zero only decides whether the target lies below the column.
				S_CHKZ: begin
					if (i_q == '0) begin
						below_q <= zt_q <= z_rd_q;
						zprev_q <= z_rd_q;
						i_q     <= AW'(1);
						state_q <= S_RDZ;
					end else if (below_q || z_rd_q >= zt_q || i_q == np_last) begin
						zr_q    <= z_rd_q;
						zrm_q   <= zprev_q;
						r_q     <= i_q;
						state_q <= S_RDL0;
					end else begin
						zprev_q <= z_rd_q;
						i_q     <= i_q + AW'(1);
						state_q <= S_RDZ;
					end
				end
				S_RDL0: state_q <= S_RDL1;
				S_RDL1: begin
					lprm_q  <= l_rd_q;
					state_q <= S_CAPL;
				end
				S_CAPL: begin
					lpr_q <= l_rd_q;
					num_q <= prod[63:0];
					dz_q  <= dz;
					neg_q <= prod[63] ^ dz[32];
					if (dz == 33'sd0) begin
						result_valid_q <= 1'b1;
						height_level_q <= k_q;
						pressure_out_q <= '0;
						div_error_q    <= 1'b1;
						last_out_q     <= k_q == nz_eff - 5'd1;
						state_q        <= S_NEXT;
					end else begin
						state_q <= S_DIVS;
					end
				end
				S_DIVS: state_q <= S_DIV;
				S_DIV: begin
					if (div_res.done) state_q <= S_EXP;
				end
				S_EXP: begin
					if (exp_res.done) begin
						result_valid_q <= 1'b1;
						height_level_q <= k_q;
						pressure_out_q <= exp_res.pressure;
						div_error_q    <= 1'b0;
						last_out_q     <= k_q == nz_eff - 5'd1;
						state_q        <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (k_q == nz_eff - 5'd1) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + 5'd1;
						acc_q   <= acc_q + 38'(step_q);
						state_q <= S_TGT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The divider sees only magnitudes; neg_q, the product's sign xor that of dz, is applied to its quotient.
	lpvi_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.value  (pressure_value),
		.res    (log_res)
	);

	lpvi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag),
		.divisor  (dz_mag),
		.res      (div_res)
	);

	lpvi_exp u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (exp_start),
		.log_in (lr),
		.res    (exp_res)
	);

	assign result_valid = result_valid_q;
	assign height_level = height_level_q;
	assign pressure_out = pressure_out_q;
	assign div_error    = div_error_q;
	assign last_out     = last_out_q;

endmodule
